/* hdl/abps_pkg.sv */
// ----------------------------------------------------------------------------
// abps_pkg: shared types and constants of the alpha blend pixel store
// Field widths, operation, status and register codes, and the sequencer
// state type used by the pixel store and its interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package abps_pkg;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int RIDX_W   = 19;
  localparam int WORD_W   = 24;
  localparam int STATUS_W = 2;
  localparam int ORDER_W  = 2;
  localparam int PITCH_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  // Pixel index before the range check: 12 bits plus 12 x 13 bits.
  localparam int IDX_W    = 26;
  localparam int PROD_W   = PITCH_W + COORD_W;
  localparam int WEIGHT_W = 9;
  localparam int ACC_W    = 16;

  localparam logic [OP_W-1:0] OP_PLOT  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_ORDER = 2'd2;

  localparam logic [ORDER_W-1:0] ORD_RGB = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_BGR = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PITCH  = 2'd1;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;

  // Three colour bytes of one entry, lane 0 in bits 7..0.
  typedef logic [2:0][CHAN_W-1:0] lanes_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_ADDR,
    S_RD_PLOT,
    S_MUL_SRC,
    S_MUL_DST,
    S_ACC,
    S_WRITE,
    S_CLEAR,
    S_RD_WORD,
    S_FINISH
  } state_t;

endpackage : abps_pkg

`default_nettype wire

/* hdl/abps_if.sv */
// ----------------------------------------------------------------------------
// abps_if: word channels of the alpha blend pixel store
// Command, result and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface abps_in_if
  import abps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [COORD_W-1:0]  pos_x;
  logic [COORD_W-1:0]  pos_y;
  logic [CHAN_W-1:0]   src_red;
  logic [CHAN_W-1:0]   src_green;
  logic [CHAN_W-1:0]   src_blue;
  logic [CHAN_W-1:0]   src_alpha;
  logic [RIDX_W-1:0]   read_index;

  modport source (output valid, op, pos_x, pos_y, src_red, src_green, src_blue,
                  src_alpha, read_index, input ready);
  modport sink (input valid, op, pos_x, pos_y, src_red, src_green, src_blue,
                src_alpha, read_index, output ready);
endinterface : abps_in_if

interface abps_out_if
  import abps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   read_word;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_word, status, input ready);
  modport sink (input valid, read_word, status, output ready);
endinterface : abps_out_if

interface abps_cfg_if
  import abps_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface : abps_cfg_if

`default_nettype wire

/* hdl/abps_ram.sv */
// ----------------------------------------------------------------------------
// abps_ram: generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module abps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 307200
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                        wdata,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : abps_ram

`default_nettype wire

/* hdl/alpha_blend_pixel_store_top.sv */
// ----------------------------------------------------------------------------
// alpha_blend_pixel_store_top: back-buffer pixel store with blended plots
// Plots blend a source colour over one stored pixel, clears fill the whole
// store, reads return one stored word. RGB and BGR byte orders.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns exactly one result
// word for it. After reset the store is swept to zero, one entry a cycle, and
// the command channel is not ready until the sweep is done (configuration
// writes are taken throughout). A read goes through decode, a memory read and
// finish; a plot through decode, address, a memory read, a source multiply, a
// destination multiply and an accumulate per channel, and a write. A read
// outside the store, a plot or clear under an unsupported byte order and the
// spare op go from decode straight to finish, a plot outside the store from
// address. These steps come from the single-port pixel RAM, one access a
// cycle, and from one shared 13 x 12 bit multiplier, which forms the scan-line
// product and then the two weighted terms of each of the three channels in
// turn. A finished result sits in an output register, so the block only waits
// on the result channel if a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_blend_pixel_store_top
  import abps_pkg::*;
#(
  parameter int STORE_PIXELS = 307200
) (
  input wire logic   clk,
  input wire logic   rst_n,
  abps_in_if.sink    in_ch,
  abps_out_if.source out_ch,
  abps_cfg_if.sink   cfg_ch
);

  localparam int ADDR_W = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_PIXELS - 1);
  localparam logic [IDX_W-1:0]  STORE_LIMIT = IDX_W'(STORE_PIXELS);

  // Sequencer state.
  state_t state_r, state_nxt;

  // Registers written through the configuration channel.
  logic [ORDER_W-1:0] order_r;
  logic [PITCH_W-1:0] pitch_r;

  // The command word, held for the length of its work.
  logic [OP_W-1:0]    op_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [CHAN_W-1:0]  alpha_r;
  logic [RIDX_W-1:0]  ridx_r;
  lanes_t             src_r;     // source colour already in memory byte order

  // Working registers.
  logic [IDX_W-1:0]   idx_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   acc_r;
  lanes_t             dst_r;
  lanes_t             mix_r;
  logic [1:0]         ch_r;
  logic [ADDR_W-1:0]  cursor_r;
  logic [WORD_W-1:0]  word_r;
  logic [STATUS_W-1:0] status_r;

  // Output register.
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [STATUS_W-1:0] out_status_r;

  // Shared multiplier and memory port.
  logic [PITCH_W-1:0] mul_a;
  logic [COORD_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  logic [IDX_W-1:0]    plot_idx;
  logic [IDX_W-1:0]    read_idx;
  logic [WEIGHT_W-1:0] w_src;
  logic [WEIGHT_W-1:0] w_dst;
  logic [ACC_W:0]      blend_sum;
  logic                in_take;
  logic                fin_go;
  logic                order_bad;

  assign in_take   = in_ch.valid && in_ch.ready;
  assign fin_go    = !out_valid_r || out_ch.ready;
  assign order_bad = (order_r != ORD_RGB) && (order_r != ORD_BGR);

  // Pixel index of a plot; computed without wrap so that large products are
  // caught by the range check.
  assign plot_idx  = IDX_W'(x_r) + IDX_W'(prod_r);
  assign read_idx  = IDX_W'(ridx_r);

  // Blend weights: (alpha + 1) for the source, (256 - alpha) for the store.
  assign w_src     = WEIGHT_W'(alpha_r) + WEIGHT_W'(1);
  assign w_dst     = WEIGHT_W'(256) - WEIGHT_W'(alpha_r);
  assign blend_sum = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(prod_r[ACC_W-1:0]);

  assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_word = out_word_r;
  assign out_ch.status    = out_status_r;

  abps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_PIXELS)
  ) u_abps_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (cursor_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_r)
          OP_PLOT:  state_nxt = order_bad ? S_FINISH : S_ADDR;
          OP_CLEAR: state_nxt = order_bad ? S_FINISH : S_CLEAR;
          OP_READ:  state_nxt = (read_idx >= STORE_LIMIT) ? S_FINISH : S_RD_WORD;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_ADDR:    state_nxt = (plot_idx >= STORE_LIMIT) ? S_FINISH : S_RD_PLOT;
      S_RD_PLOT: state_nxt = S_MUL_SRC;
      S_MUL_SRC: state_nxt = S_MUL_DST;
      S_MUL_DST: state_nxt = S_ACC;
      S_ACC:     state_nxt = (ch_r == 2'd2) ? S_WRITE : S_MUL_SRC;
      S_WRITE:   state_nxt = S_FINISH;
      S_CLEAR: begin
        if (cursor_r == LAST_ADDR) begin
          state_nxt = S_FINISH;
        end
      end
      S_RD_WORD: state_nxt = S_FINISH;
      S_FINISH: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_INIT;
    endcase
  end

  // Multiplier operands and memory port controls.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_addr  = cursor_r;
    ram_wdata = '0;
    unique case (state_r)
      S_INIT: begin
        ram_we = 1'b1;
      end
      S_DECODE: begin
        // Scan-line product for a plot; address of a read.
        mul_a    = pitch_r;
        mul_b    = y_r;
        ram_addr = read_idx[ADDR_W-1:0];
      end
      S_ADDR: begin
        ram_addr = plot_idx[ADDR_W-1:0];
      end
      S_MUL_SRC: begin
        mul_a = PITCH_W'(w_src);
        mul_b = COORD_W'(src_r[ch_r]);
      end
      S_MUL_DST: begin
        mul_a = PITCH_W'(w_dst);
        mul_b = COORD_W'(dst_r[ch_r]);
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = idx_r[ADDR_W-1:0];
        ram_wdata = mix_r;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = src_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      order_r     <= ORD_RGB;
      pitch_r     <= PITCH_RESET;
      cursor_r    <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PIXEL_ORDER: order_r <= cfg_ch.data[ORDER_W-1:0];
          REG_SCAN_PITCH:  pitch_r <= cfg_ch.data[PITCH_W-1:0];
          default: begin
          end
        endcase
      end

      // The sweep cursor walks the store for the reset pass and for a clear,
      // and rests at zero otherwise.
      if ((state_r == S_INIT) || (state_r == S_CLEAR)) begin
        cursor_r <= (cursor_r == LAST_ADDR) ? '0 : cursor_r + ADDR_W'(1);
      end

      if (state_r == S_RD_PLOT) begin
        ch_r <= '0;
      end else if (state_r == S_ACC) begin
        ch_r <= ch_r + 2'd1;
      end

      // A finished result fills the output register, which may be emptied by
      // the same edge; otherwise a taken result leaves it empty.
      if ((state_r == S_FINISH) && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= in_ch.op;
      x_r     <= in_ch.pos_x;
      y_r     <= in_ch.pos_y;
      alpha_r <= in_ch.src_alpha;
      ridx_r  <= in_ch.read_index;
      if (order_r == ORD_RGB) begin
        src_r[0] <= in_ch.src_red;
        src_r[2] <= in_ch.src_blue;
      end else begin
        src_r[0] <= in_ch.src_blue;
        src_r[2] <= in_ch.src_red;
      end
      src_r[1] <= in_ch.src_green;
    end

    unique case (state_r)
      S_DECODE: begin
        prod_r   <= mul_p;
        word_r   <= '0;
        status_r <= STS_DONE;
        case (op_r)
          OP_PLOT, OP_CLEAR: begin
            if (order_bad) begin
              status_r <= STS_ORDER;
            end
          end
          OP_READ: begin
            if (read_idx >= STORE_LIMIT) begin
              status_r <= STS_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      S_ADDR: begin
        idx_r <= plot_idx;
        if (plot_idx >= STORE_LIMIT) begin
          status_r <= STS_RANGE;
        end
      end
      S_RD_PLOT: begin
        dst_r <= ram_rdata;
      end
      S_MUL_SRC: begin
        prod_r <= mul_p;
      end
      S_MUL_DST: begin
        acc_r  <= prod_r[ACC_W-1:0];
        prod_r <= mul_p;
      end
      S_ACC: begin
        mix_r[ch_r] <= blend_sum[ACC_W-1:CHAN_W];
      end
      S_RD_WORD: begin
        word_r <= ram_rdata;
      end
      S_FINISH: begin
        if (fin_go) begin
          out_word_r   <= word_r;
          out_status_r <= status_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule : alpha_blend_pixel_store_top

`default_nettype wire

/* hdl/abps_checker.sv */
// ----------------------------------------------------------------------------
// abps_checker: port-level checks of the alpha blend pixel store
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abps_checker
  import abps_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  abps_in_if.sink    in_ch,
  abps_out_if.source out_ch
);

  // One command at a time: the block is busy straight after taking a word.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command channel ready again straight after a word was taken");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == STS_DONE || out_ch.status == STS_RANGE ||
                      out_ch.status == STS_ORDER))
    else $error("result carries an unknown status code");

  // A failed command never returns stored data.
  a_fail_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STS_DONE)) |-> (out_ch.read_word == '0))
    else $error("failed command returned a non-zero word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.read_word) && $stable(out_ch.status)))
    else $error("stalled result word changed or was withdrawn");

endmodule : abps_checker

bind alpha_blend_pixel_store_top abps_checker u_abps_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the alpha blend pixel store
// Streams plot, clear, read and spare-op command words into the store, keeps
// a shadow copy of the pixel memory and the two registers, and compares every
// result word against the shadow's answer under random idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;

  import abps_pkg::*;

  // The store is kept at its production size. The sweep after reset and a
  // full clear each walk every entry of it, so only one real clear is issued
  // and the watchdog is sized well beyond the longest silent stretch.
  localparam int unsigned PIXELS          = 307200;
  localparam int unsigned WATCHDOG_CYCLES = 4 * (PIXELS + 64);
  localparam int unsigned DRAIN_CYCLES    = 16;

  // Codes that the package leaves unnamed: the spare operation, the two
  // unsupported byte orders and the two unused register slots.
  localparam logic [OP_W-1:0]      OP_SPARE   = 2'd3;
  localparam logic [ORDER_W-1:0]   ORD_MASK   = 2'd2;
  localparam logic [ORDER_W-1:0]   ORD_BLIT   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic [RIDX_W-1:0]  read_index;
  } pixel_cmd_t;

  typedef struct {
    logic [WORD_W-1:0]   read_word;
    logic [STATUS_W-1:0] status;
  } pixel_result_t;

  logic clk;
  logic rst_n;

  abps_in_if  cmd_if ();
  abps_out_if res_if ();
  abps_cfg_if reg_if ();

  alpha_blend_pixel_store_top #(
    .STORE_PIXELS (PIXELS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (res_if),
    .cfg_ch (reg_if)
  );

  // Shadow of the block: the pixel memory, the two registers, the commands
  // still to be sent and the result words the block still owes us.
  lanes_t             shadow_pixels [PIXELS];
  logic [ORDER_W-1:0] shadow_order;
  logic [PITCH_W-1:0] shadow_pitch;
  pixel_cmd_t         cmd_backlog [$];
  pixel_result_t      due_words [$];
  int unsigned        faults;
  bit                 in_quiet;
  bit                 out_quiet;
  int unsigned        hot_x [16];
  int unsigned        hot_y [16];

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length for either side: mostly none or a short one, now and then a
  // long pause. A quiet side never idles.
  function automatic int unsigned idle_pick(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(30, 120);
  endfunction

  function automatic pixel_cmd_t pack_cmd(input logic [OP_W-1:0] op,
                                          input int unsigned x, y, r, g, b, a,
                                          input int unsigned ridx);
    pixel_cmd_t c;
    c.op         = op;
    c.pos_x      = x[COORD_W-1:0];
    c.pos_y      = y[COORD_W-1:0];
    c.red        = r[CHAN_W-1:0];
    c.green      = g[CHAN_W-1:0];
    c.blue       = b[CHAN_W-1:0];
    c.alpha      = a[CHAN_W-1:0];
    c.read_index = ridx[RIDX_W-1:0];
    return c;
  endfunction

  // One channel of the blend: (alpha + 1) parts source over (256 - alpha)
  // parts destination, scaled back down by 256.
  function automatic logic [CHAN_W-1:0] blend_lane(input logic [CHAN_W-1:0] s, d, a);
    int unsigned mix;
    mix = (32'(a) + 1) * 32'(s) + (256 - 32'(a)) * 32'(d);
    return 8'(mix >> 8);
  endfunction

  // Applies one accepted command to the shadow and returns the result word
  // the block must answer with.
  function automatic pixel_result_t pixel_store_step(input pixel_cmd_t c);
    pixel_result_t     res;
    lanes_t            ent;
    lanes_t            fill;
    int unsigned       idx;
    logic [CHAN_W-1:0] dst_r, dst_b, new_r, new_g, new_b;
    res.read_word = '0;
    res.status    = STS_DONE;
    case (c.op)
      OP_PLOT: begin
        if (shadow_order > ORD_BGR) begin
          res.status = STS_ORDER;
        end else begin
          // Index is formed at full width, so a large pitch cannot wrap back
          // into the store.
          idx = 32'(c.pos_x) + 32'(c.pos_y) * 32'(shadow_pitch);
          if (idx >= PIXELS) begin
            res.status = STS_RANGE;
          end else begin
            ent = shadow_pixels[idx];
            if (shadow_order == ORD_RGB) begin
              dst_r = ent[0];
              dst_b = ent[2];
            end else begin
              dst_r = ent[2];
              dst_b = ent[0];
            end
            new_r = blend_lane(c.red, dst_r, c.alpha);
            new_g = blend_lane(c.green, ent[1], c.alpha);
            new_b = blend_lane(c.blue, dst_b, c.alpha);
            shadow_pixels[idx] = (shadow_order == ORD_RGB) ? {new_b, new_g, new_r}
                                                           : {new_r, new_g, new_b};
          end
        end
      end
      OP_CLEAR: begin
        if (shadow_order > ORD_BGR) begin
          res.status = STS_ORDER;
        end else begin
          fill = (shadow_order == ORD_RGB) ? {c.blue, c.green, c.red}
                                           : {c.red, c.green, c.blue};
          foreach (shadow_pixels[i]) shadow_pixels[i] = fill;
        end
      end
      OP_READ: begin
        // A read ignores the byte order altogether.
        if (32'(c.read_index) >= PIXELS) res.status = STS_RANGE;
        else res.read_word = shadow_pixels[c.read_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver. A new word is presented as soon as the previous one has
  // been taken and its gap has run out; valid stays high across back-to-back
  // words. The shadow is advanced at the edge that accepts the word.
  // ---------------------------------------------------------------------------
  pixel_cmd_t  live_cmd;
  int unsigned in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        due_words.push_back(pixel_store_step(live_cmd));
        in_gap = idle_pick(in_quiet);
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          live_cmd = cmd_backlog.pop_front();
          cmd_if.op         <= live_cmd.op;
          cmd_if.pos_x      <= live_cmd.pos_x;
          cmd_if.pos_y      <= live_cmd.pos_y;
          cmd_if.src_red    <= live_cmd.red;
          cmd_if.src_green  <= live_cmd.green;
          cmd_if.src_blue   <= live_cmd.blue;
          cmd_if.src_alpha  <= live_cmd.alpha;
          cmd_if.read_index <= live_cmd.read_index;
          cmd_if.valid      <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Every word taken is matched against the oldest owed word.
  // Ready may be dropped for a while after a take and, now and then, at random.
  // ---------------------------------------------------------------------------
  pixel_result_t owed;
  int unsigned   out_hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_words.size() == 0) begin
          $error("result word taken with no command outstanding");
          faults++;
        end else begin
          owed = due_words.pop_front();
          if (res_if.read_word !== owed.read_word) begin
            $error("read_word: expected %06h, got %06h", owed.read_word, res_if.read_word);
            faults++;
          end
          if (res_if.status !== owed.status) begin
            $error("status: expected %0d, got %0d", owed.status, res_if.status);
            faults++;
          end
        end
        out_hold = idle_pick(out_quiet);
      end else if (out_hold == 0 && !out_quiet && $urandom_range(0, 15) == 0) begin
        out_hold = idle_pick(1'b0);
      end
      if (out_hold > 0) begin
        out_hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any stretch without a single handshake on any channel that
  // outlasts the reset sweep and a full clear several times over is a hang.
  int unsigned silent_cycles;

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles >= WATCHDOG_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Register write, one word on the configuration channel. The shadow copy
  // of the register follows at the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!(reg_if.valid && reg_if.ready));
    if (idx == REG_PIXEL_ORDER) shadow_order = val[ORDER_W-1:0];
    else if (idx == REG_SCAN_PITCH) shadow_pitch = val[PITCH_W-1:0];
    reg_if.valid <= 1'b0;
  endtask

  // Holds off until every queued command has gone and every owed word has
  // come back, then lets the block settle.
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_if.valid || due_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [ORDER_W-1:0] order, input int unsigned pitch);
    drain();
    write_reg(REG_PIXEL_ORDER, order);
    write_reg(REG_SCAN_PITCH, pitch);
    @(negedge clk);
  endtask

  // Coordinates that land inside the store for the current pitch.
  task automatic pick_inside(output int unsigned x, y);
    int unsigned p, ylim, xlim;
    p = shadow_pitch;
    if (p == 0) begin
      y = $urandom_range(0, 4095);
      x = $urandom_range(0, 4095);
    end else begin
      ylim = (PIXELS - 1) / p;
      if (ylim > 4095) ylim = 4095;
      y = $urandom_range(0, ylim);
      xlim = PIXELS - 1 - y * p;
      if (xlim > 4095) xlim = 4095;
      x = $urandom_range(0, xlim);
    end
  endtask

  // Random traffic for one register setting. Most words are plots inside
  // the store and reads of recently plotted pixels, so repeated blends on
  // the same entry are read back; the rest is wild coordinates, stray reads,
  // the spare op and, only where the order makes it cheap, clears.
  task automatic random_burst(input int unsigned count);
    pixel_cmd_t  c;
    int unsigned roll, slot, x, y, a;
    for (int i = 0; i < 16; i++) pick_inside(hot_x[i], hot_y[i]);
    repeat (count) begin
      roll = $urandom_range(0, 9);
      a = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
      c = pack_cmd(OP_PLOT, $urandom, $urandom, $urandom, $urandom, $urandom, a,
                   $urandom);
      slot = $urandom_range(0, 15);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        pick_inside(x, y);
        hot_x[slot] = x;
        hot_y[slot] = y;
        c.pos_x = x[COORD_W-1:0];
        c.pos_y = y[COORD_W-1:0];
      end else if (roll < 60) begin
        c.pos_x = hot_x[slot][COORD_W-1:0];
        c.pos_y = hot_y[slot][COORD_W-1:0];
      end else if (roll < 85) begin
        c.op = OP_READ;
        if ($urandom_range(0, 9) < 7) begin
          x = hot_x[slot] + hot_y[slot] * shadow_pitch;
          c.read_index = x[RIDX_W-1:0];
        end
      end else if (roll < 94) begin
        // wild coordinates as drawn, often outside the store
      end else if (roll < 97) begin
        c.op = OP_SPARE;
      end else begin
        c.op = (shadow_order > ORD_BGR) ? OP_CLEAR : OP_READ;
      end
      cmd_backlog.push_back(c);
    end
  endtask

  logic [ORDER_W-1:0] burst_order [8] = '{ORD_RGB, ORD_BGR, ORD_RGB, ORD_BGR,
                                          ORD_MASK, ORD_RGB, ORD_BLIT, ORD_BGR};

  // ---------------------------------------------------------------------------
  // Stimulus: reset, a directed pass over the extremes and the special cases,
  // then eight random bursts under different register settings.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pitch;
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.op         = OP_PLOT;
    cmd_if.pos_x      = '0;
    cmd_if.pos_y      = '0;
    cmd_if.src_red    = '0;
    cmd_if.src_green  = '0;
    cmd_if.src_blue   = '0;
    cmd_if.src_alpha  = '0;
    cmd_if.read_index = '0;
    res_if.ready      = 1'b0;
    reg_if.valid      = 1'b0;
    reg_if.index      = REG_PIXEL_ORDER;
    reg_if.data       = '0;
    faults            = 0;
    in_quiet          = 1'b0;
    out_quiet         = 1'b0;
    shadow_order      = ORD_RGB;
    shadow_pitch      = PITCH_RESET;
    foreach (shadow_pixels[i]) shadow_pixels[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the store must read as zero, and the pitch of 640 puts
    // (639, 1) at entry 1279. An opaque plot then a fully transparent one.
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, PIXELS - 1));
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 639, 1, 255, 0, 128, 255, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1279));
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 639, 1, 0, 255, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1279));
    // Plots just past the end and at the far corner, reads past the end.
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 0, 480, 255, 255, 255, 255, 0));
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 4095, 4095, 255, 255, 255, 255, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, PIXELS));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 32'h7FFFF));
    cmd_backlog.push_back(pack_cmd(OP_SPARE, 4095, 4095, 255, 255, 255, 255, 32'h7FFFF));

    // The one real clear, in blue-green-red order so the fill is byte-swapped,
    // then a half-opaque white plot at the widest x with a pitch of one.
    set_config(ORD_BGR, 1);
    cmd_backlog.push_back(pack_cmd(OP_CLEAR, 0, 0, 8'h12, 8'h34, 8'h56, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 4095, 0, 255, 255, 255, 128, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 4095));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));

    // Pitches outside the documented range are used as written: zero makes
    // y irrelevant, the largest 13-bit value still lands inside for small y.
    set_config(ORD_RGB, 0);
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 100, 4095, 10, 200, 30, 200, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 100));
    set_config(ORD_RGB, 8191);
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 5, 37, 77, 88, 99, 1, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 303072));
    set_config(ORD_RGB, 4096);
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 0, 75, 1, 2, 3, 254, 0));
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 0, 74, 1, 2, 3, 254, 0));

    // Unsupported orders refuse plots and clears but still serve reads.
    set_config(ORD_MASK, 4096);
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 0, 74, 255, 255, 255, 255, 0));
    cmd_backlog.push_back(pack_cmd(OP_CLEAR, 0, 0, 255, 255, 255, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 303104));
    set_config(ORD_BLIT, 4096);
    cmd_backlog.push_back(pack_cmd(OP_PLOT, 1, 1, 0, 0, 0, 255, 0));
    cmd_backlog.push_back(pack_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));

    // Writes to the unused register slots must change nothing.
    drain();
    write_reg(REG_SPARE2, 13'h1FFF);
    write_reg(REG_SPARE3, 13'h1FFF);

    // Random bursts. Each one starts from an idle block with a fresh setting;
    // the gap between bursts is where the sender waits for every owed word.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 1) pitch = 4096;
      else if (ph == 2) pitch = 1;
      else if (ph == 7) pitch = $urandom_range(4097, 8191);
      else pitch = $urandom_range(1, 4096);
      set_config(burst_order[ph], pitch);
      in_quiet  = (ph == 5);
      out_quiet = (ph == 5);
      random_burst((burst_order[ph] > ORD_BGR) ? 100 : 250);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0 && due_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : tb_top
